/* design/ksbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksbm_pkg
// Shared types and constants of the key-sequence binding matcher.
// ----------------------------------------------------------------------------
package ksbm_pkg;

  localparam int unsigned MaxBinds    = 64;
  localparam int unsigned MaxBindLen  = 8;
  localparam int unsigned MacroDepth  = 1024;
  localparam int unsigned KeyW        = 21;
  localparam int unsigned ActW        = 8;
  localparam int unsigned BindIdxW    = $clog2(MaxBinds);
  localparam int unsigned BindCntW    = $clog2(MaxBinds + 1);
  localparam int unsigned LenW        = $clog2(MaxBindLen + 1);
  localparam int unsigned PosW        = (MaxBindLen > 1) ? $clog2(MaxBindLen) : 1;
  localparam int unsigned MacIdxW     = $clog2(MacroDepth);
  localparam int unsigned MacCntW     = $clog2(MacroDepth + 1);

  localparam logic [KeyW-1:0] ReplacementChar = KeyW'(21'h00FFFD);

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_APPEND = 3'd1,
    OP_COMMIT = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_RECORD = 3'd4,
    OP_STOP   = 3'd5,
    OP_REPLAY = 3'd6,
    OP_NONE   = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_EXEC = 2'd2
  } macro_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MACRO,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [KeyW-1:0] key_code;
    logic [ActW-1:0] action_id;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] key_out;
    logic            swallowed;
    logic            fired;
    logic [ActW-1:0] fired_action;
    logic            recording;
    logic            error_flag;
  } out_item_t;

  // Control from the sequencer to every cell of the binding chain.
  typedef struct packed {
    logic            clear;      // drop all bindings
    logic            write;      // store staged sequence at the tail
    logic            scan;       // shift one binding through the compare
    logic [LenW-1:0] wr_len;
  } chain_ctl_t;

endpackage

/* design/ksbm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksbm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ksbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* design/ksbm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksbm_cell
// One binding slot of the rotating chain: sequence, length, action, valid.
// ----------------------------------------------------------------------------
module ksbm_cell (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  ksbm_pkg::chain_ctl_t                             ctl_i,
  input  logic                                             wr_sel_i,
  input  logic [ksbm_pkg::MaxBindLen-1:0][ksbm_pkg::KeyW-1:0] wr_chars_i,
  input  logic [ksbm_pkg::ActW-1:0]                        wr_act_i,
  input  logic                                             act_upd_i,
  input  logic                                             prev_vld_i,
  input  logic [ksbm_pkg::LenW-1:0]                        prev_len_i,
  input  logic [ksbm_pkg::ActW-1:0]                        prev_act_i,
  input  logic [ksbm_pkg::MaxBindLen-1:0][ksbm_pkg::KeyW-1:0] prev_chars_i,
  output logic                                             vld_o,
  output logic [ksbm_pkg::LenW-1:0]                        len_o,
  output logic [ksbm_pkg::ActW-1:0]                        act_o,
  output logic [ksbm_pkg::MaxBindLen-1:0][ksbm_pkg::KeyW-1:0] chars_o
);
  import ksbm_pkg::*;

  logic vld_q;
  logic [LenW-1:0] len_q;
  logic [ActW-1:0] act_q;
  logic [MaxBindLen-1:0][KeyW-1:0] chars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctl_i.scan) begin
      vld_q <= prev_vld_i;
    end else if (ctl_i.write && wr_sel_i) begin
      vld_q <= 1'b1;
    end
  end

  // Rotate the payload with the valid bit, patching the action on the way; load in place.
  always_ff @(posedge clk_i) begin
    if (ctl_i.scan) begin
      len_q   <= prev_len_i;
      act_q   <= act_upd_i ? wr_act_i : prev_act_i;
      chars_q <= prev_chars_i;
    end else if (ctl_i.write && wr_sel_i) begin
      len_q   <= ctl_i.wr_len;
      act_q   <= wr_act_i;
      chars_q <= wr_chars_i;
    end
  end

  assign vld_o   = vld_q;
  assign len_o   = len_q;
  assign act_o   = act_q;
  assign chars_o = chars_q;

endmodule

/* design/key_sequence_binding_matcher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_sequence_binding_matcher_top
// Key-sequence binding matcher with macro record and replay.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item_i and raise start_i while busy_o is low; the item is taken at
//   that edge. Exactly one result item appears on result_o, marked by done_o
//   for one cycle. The receiver cannot stall; the result is simply held in
//   the output register until the next item replaces it.
//   Bindings live in a ring of MaxBinds cells. A read key with a non-empty
//   table, or a commit that reaches the table, rotates the whole ring once
//   through cell 0, comparing one binding per cycle. The macro RAM read is
//   hidden in the first busy cycle. A read key with an empty table, a commit
//   with nothing staged or a full table, and all other opcodes skip the
//   rotation and go from the macro step straight to done. One item is in
//   flight at a time.
//   Reset empties the table, staging and prefix and stops any macro; stored
//   RAM contents are kept but never read before being written again.
// ----------------------------------------------------------------------------
module key_sequence_binding_matcher_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ksbm_pkg::in_item_t   item_i,
  output logic                 busy_o,
  output logic                 done_o,
  output ksbm_pkg::out_item_t  result_o
);
  import ksbm_pkg::*;

  state_e state_q, state_d;
  in_item_t item_q;
  out_item_t res_q, res_d;
  logic done_q;

  logic [BindCntW-1:0] cnt_q, cnt_d;
  logic [BindCntW-1:0] step_q, step_d;
  logic [MaxBindLen-1:0][KeyW-1:0] stg_q, stg_d, pfx_q, pfx_d;
  logic [LenW-1:0] stg_len_q, stg_len_d, pfx_len_q, pfx_len_d;
  macro_mode_e mode_q, mode_d;
  logic [MacCntW-1:0] mlen_q, mlen_d, mcur_q, mcur_d;
  logic [KeyW-1:0] key_q, key_d;
  logic hit_q, hit_d, pre_q, pre_d, err_q, err_d;
  logic [ActW-1:0] hact_q, hact_d;

  // RAM
  logic m_we;
  logic [MacIdxW-1:0] m_addr;
  logic [KeyW-1:0] m_rdata;

  ksbm_ram #(.Width(KeyW), .Depth(MacroDepth)) u_macro (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(item_q.key_code),
    .rdata_o(m_rdata)
  );

  // Chain
  chain_ctl_t ctl;
  logic [MaxBinds-1:0] c_vld;
  logic [MaxBinds-1:0][LenW-1:0] c_len;
  logic [MaxBinds-1:0][ActW-1:0] c_act;
  logic [MaxBinds-1:0][MaxBindLen-1:0][KeyW-1:0] c_chars;
  logic upd_now;

  for (genvar g = 0; g < MaxBinds; g++) begin : g_cell
    localparam int unsigned Prev = (g + 1) % MaxBinds;
    ksbm_cell u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl),
      .wr_sel_i(cnt_q[BindIdxW-1:0] == BindIdxW'(g)),
      .wr_chars_i(stg_q), .wr_act_i(item_q.action_id),
      .act_upd_i((g == MaxBinds - 1) && upd_now),
      .prev_vld_i(c_vld[Prev]), .prev_len_i(c_len[Prev]),
      .prev_act_i(c_act[Prev]), .prev_chars_i(c_chars[Prev]),
      .vld_o(c_vld[g]), .len_o(c_len[g]), .act_o(c_act[g]),
      .chars_o(c_chars[g])
    );
  end

  // Compare cell 0 against the working sequence (prefix or staging).
  logic is_read;
  logic [MaxBindLen-1:0][KeyW-1:0] cmp_seq;
  logic [LenW-1:0] cmp_len;
  logic head_eq;
  logic fire_now, pre_now;
  assign is_read = (item_q.opcode == OP_READ);
  assign cmp_seq = is_read ? pfx_q : stg_q;
  assign cmp_len = is_read ? pfx_len_q : stg_len_q;
  always_comb begin
    head_eq = 1'b1;
    for (int i = 0; i < MaxBindLen; i++) begin
      if (LenW'(i) < cmp_len && c_chars[0][i] != cmp_seq[i]) begin
        head_eq = 1'b0;
      end
    end
  end
  // Patch the action of a repeated commit as its binding leaves cell 0 for
  // the last cell of the ring.
  assign upd_now = (state_q == ST_SCAN) && !is_read && fire_now && !hit_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_MACRO;
      ST_MACRO: begin
        if ((item_q.opcode == OP_READ && cnt_q != '0) ||
            (item_q.opcode == OP_COMMIT && stg_len_q != '0 &&
             cnt_q < BindCntW'(MaxBinds)))
          state_d = ST_SCAN;
        else state_d = ST_DONE;
      end
      ST_SCAN: if (step_q == BindCntW'(MaxBinds)) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath.
  logic exec_ok;
  always_comb begin
    cnt_d = cnt_q; step_d = step_q; stg_d = stg_q; stg_len_d = stg_len_q;
    pfx_d = pfx_q; pfx_len_d = pfx_len_q; mode_d = mode_q;
    mlen_d = mlen_q; mcur_d = mcur_q; key_d = key_q;
    hit_d = hit_q; pre_d = pre_q; err_d = err_q; hact_d = hact_q;
    res_d = res_q;
    ctl = '0; ctl.wr_len = stg_len_q;
    m_we = 1'b0; m_addr = mcur_q[MacIdxW-1:0];
    exec_ok = (mcur_q < MacCntW'(MacroDepth)) && (mcur_q + 1'b1 < mlen_q);
    fire_now = 1'b0; pre_now = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        key_d = item_i.key_code; hit_d = 1'b0; pre_d = 1'b0; err_d = 1'b0;
        hact_d = '0; step_d = '0;
        if (item_i.opcode == OP_READ && mode_q == MODE_REC)
          m_addr = mlen_q[MacIdxW-1:0];
      end
      ST_MACRO: begin
        // Registered RAM read of the cursor lands this cycle.
        unique case (item_q.opcode)
          OP_READ: begin
            if (mode_q == MODE_EXEC) begin
              if (exec_ok) begin
                key_d = m_rdata; mcur_d = mcur_q + 1'b1;
              end else begin
                mode_d = MODE_IDLE; pfx_len_d = '0;
              end
            end else if (mode_q == MODE_REC) begin
              m_addr = mlen_q[MacIdxW-1:0];
              if (mlen_q < MacCntW'(MacroDepth)) begin
                m_we = 1'b1; mlen_d = mlen_q + 1'b1;
              end else err_d = 1'b1;
            end
          end
          OP_APPEND: begin
            if (stg_len_q < LenW'(MaxBindLen)) begin
              stg_d[stg_len_q[PosW-1:0]] = item_q.key_code;
              stg_len_d = stg_len_q + 1'b1;
            end else err_d = 1'b1;
          end
          OP_COMMIT: begin
            if (stg_len_q != '0 && cnt_q >= BindCntW'(MaxBinds)) begin
              err_d = 1'b1; stg_len_d = '0;
            end else if (stg_len_q == '0) stg_len_d = '0;
          end
          OP_CLEAR: begin
            ctl.clear = 1'b1; cnt_d = '0; pfx_len_d = '0;
          end
          OP_RECORD: begin mode_d = MODE_REC; mlen_d = '0; end
          OP_STOP:   mode_d = MODE_IDLE;
          OP_REPLAY: begin mode_d = MODE_EXEC; mcur_d = '0; end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (is_read && step_q == '0) begin
          // Extend the prefix before the compare rotation begins, or empty it when it is full.
          if (pfx_len_q < LenW'(MaxBindLen)) begin
            pfx_d[pfx_len_q[PosW-1:0]] = key_q;
            pfx_len_d = pfx_len_q + 1'b1;
          end else pfx_len_d = '0;
          step_d = step_q + 1'b1;
          ctl.scan = 1'b0;
        end else if (step_q < BindCntW'(MaxBinds) + (is_read ? 1'b1 : 1'b0) &&
                     !(is_read && step_q == BindCntW'(MaxBinds) + 1'b1)) begin
          ctl.scan = 1'b1;
          step_d = step_q + 1'b1;
        end
        // Cell 0 holds binding number (step - read offset) before the shift.
        if (c_vld[0] && ((is_read && step_q != '0) || !is_read)) begin
          fire_now = (c_len[0] == cmp_len) && head_eq;
          pre_now  = (c_len[0] >= cmp_len) && head_eq;
        end
        if (fire_now && !hit_q) begin
          hit_d = 1'b1; hact_d = c_act[0];
        end
        if (pre_now) pre_d = 1'b1;
      end
      ST_DONE: begin
        res_d = '0;
        res_d.recording = (mode_q == MODE_REC);
        res_d.error_flag = err_q;
        if (is_read) begin
          res_d.key_out = key_q;
          if (cnt_q != '0) begin
            if (hit_q) begin
              res_d.fired = 1'b1; res_d.fired_action = hact_q;
              res_d.swallowed = 1'b1; res_d.key_out = ReplacementChar;
              pfx_len_d = '0;
            end else if (pre_q) begin
              res_d.swallowed = 1'b1; res_d.key_out = ReplacementChar;
            end else pfx_len_d = '0;
          end
        end else if (item_q.opcode == OP_COMMIT && stg_len_q != '0 &&
                     cnt_q < BindCntW'(MaxBinds)) begin
          stg_len_d = '0;
          if (!hit_q) begin
            ctl.write = 1'b1; cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; step_q <= '0; stg_len_q <= '0;
      pfx_len_q <= '0; mode_q <= MODE_IDLE; mlen_q <= '0; mcur_q <= '0;
      done_q <= 1'b0; hit_q <= 1'b0; pre_q <= 1'b0; err_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; step_q <= step_d;
      stg_len_q <= stg_len_d; pfx_len_q <= pfx_len_d; mode_q <= mode_d;
      mlen_q <= mlen_d; mcur_q <= mcur_d; done_q <= (state_q == ST_DONE);
      hit_q <= hit_d; pre_q <= pre_d; err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) item_q <= item_i;
    stg_q <= stg_d; pfx_q <= pfx_d; key_q <= key_d; hact_q <= hact_d;
    res_q <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
